// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the parser RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is high.
`define STIP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked check that also holds during reset.
`define STIP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ----- hdl/stip_pkg.sv -----
// Package for the string-to-integer parser: payload types, config codes,
// character constants. No dependencies.
package stip_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIX  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED = 1'd1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CASE_BIT = 8'h20;

  localparam logic [5:0] RADIX_AUTO = 6'd0;
  localparam logic [5:0] RADIX_MIN  = 6'd2;
  localparam logic [5:0] RADIX_MAX  = 6'd36;
  localparam logic [5:0] BASE_BIN   = 6'd2;
  localparam logic [5:0] BASE_OCT   = 6'd8;
  localparam logic [5:0] BASE_DEC   = 6'd10;
  localparam logic [5:0] BASE_HEX   = 6'd16;
  localparam logic [5:0] DIGIT_NONE = 6'd37;

  typedef struct packed {
    logic [5:0] radix;
    logic       signed_mode;
  } cfg_t;

  typedef struct packed {
    logic [31:0] value;
    logic [15:0] end_offset;
    logic        status;
    logic        overflowed;
  } result_t;

endpackage

// ----- hdl/stip_stream_if.sv -----
// Valid/ready stream interface carrying one payload per transfer.
// No dependencies; payload type set per instance.
interface stip_stream_if #(parameter type payload_t = logic [7:0]);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- hdl/stip_step.sv -----
// Per-character parse step: string state registers and the next-state logic.
// Depends on stip_pkg and assert_macros.svh.
`include "assert_macros.svh"

module stip_step #(
  parameter int MAX_CHARS = 65535
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              ch_valid,
  input  logic [7:0]        ch,
  input  stip_pkg::cfg_t    cfg,
  input  logic              can_take,
  output logic              advance,
  output logic              res_load,
  output stip_pkg::result_t res
);
  import stip_pkg::*;

  localparam logic [15:0] MaxIdx = 16'(MAX_CHARS);

  typedef enum logic [2:0] {
    PH_WS, PH_SIGN, PH_PREFIX, PH_DIGITS, PH_DONE, PH_ERR
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] accum, accum_next;
  logic        ovf_flag, ovf_flag_next;
  logic        neg_flag, neg_flag_next;
  logic [5:0]  eff_base, eff_base_next;
  logic        progress_seen, progress_seen_next;
  logic [15:0] char_index, char_index_next;
  logic [15:0] stop_index, stop_index_next;

  logic        is_nul, is_ws, bad_radix, do_digit;
  logic [7:0]  upper;
  logic [5:0]  dv, base_d;
  logic [37:0] prod;
  logic [31:0] raw;
  logic        ok;

  function automatic logic [5:0] digit_value(input logic [7:0] c);
    logic [7:0] u;
    u = c & ~CASE_BIT;
    if (c >= CH_ZERO && c <= CH_NINE) return 6'(c - CH_ZERO);
    if (u >= CH_UA && u <= CH_UZ) return 6'(u - CH_UA) + BASE_DEC;
    return DIGIT_NONE;
  endfunction

  assign is_nul    = (ch == CH_NUL);
  assign is_ws     = (ch == CH_SPACE) || (ch == CH_TAB);
  assign upper     = ch & ~CASE_BIT;
  assign dv        = digit_value(ch);
  assign bad_radix = (cfg.radix != RADIX_AUTO) &&
                     ((cfg.radix < RADIX_MIN) || (cfg.radix > RADIX_MAX));

  assign advance  = ch_valid && (!is_nul || can_take);
  assign res_load = advance && is_nul;

  always_comb begin
    phase_next         = phase;
    accum_next         = accum;
    ovf_flag_next      = ovf_flag;
    neg_flag_next      = neg_flag;
    eff_base_next      = eff_base;
    progress_seen_next = progress_seen;
    stop_index_next    = stop_index;
    do_digit           = 1'b0;
    base_d             = eff_base;

    unique case (phase)
      PH_WS: begin
        if (!is_ws) begin
          eff_base_next = cfg.radix;
          base_d        = cfg.radix;
          if (bad_radix) begin
            phase_next = PH_ERR;
          end else if (ch == CH_MINUS) begin
            neg_flag_next = 1'b1;
            phase_next    = PH_SIGN;
          end else if (ch == CH_ZERO) begin
            progress_seen_next = 1'b1;
            phase_next         = PH_PREFIX;
          end else begin
            if (cfg.radix == RADIX_AUTO) base_d = BASE_DEC;
            do_digit = 1'b1;
          end
        end
      end
      PH_SIGN: begin
        if (ch == CH_ZERO) begin
          progress_seen_next = 1'b1;
          phase_next         = PH_PREFIX;
        end else begin
          if (eff_base == RADIX_AUTO) base_d = BASE_DEC;
          do_digit = 1'b1;
        end
      end
      PH_PREFIX: begin
        if (upper == CH_UB) begin
          if (eff_base != RADIX_AUTO && eff_base != BASE_BIN) begin
            phase_next = PH_ERR;
          end else begin
            eff_base_next = BASE_BIN;
            phase_next    = PH_DIGITS;
          end
        end else if (upper == CH_UX) begin
          if (eff_base != RADIX_AUTO && eff_base != BASE_HEX) begin
            phase_next = PH_ERR;
          end else begin
            eff_base_next = BASE_HEX;
            phase_next    = PH_DIGITS;
          end
        end else begin
          if (eff_base == RADIX_AUTO) base_d = BASE_OCT;
          do_digit = 1'b1;
        end
      end
      PH_DIGITS: do_digit = 1'b1;
      default: ;
    endcase

    prod = {6'd0, accum} * {32'd0, base_d} + {32'd0, dv};

    if (do_digit) begin
      eff_base_next      = base_d;
      progress_seen_next = 1'b1;
      if (dv >= base_d) begin
        stop_index_next = char_index;
        phase_next      = PH_DONE;
      end else begin
        phase_next = PH_DIGITS;
        if (!ovf_flag) begin
          ovf_flag_next = |prod[37:32];
          accum_next    = prod[31:0];
        end
      end
    end

    char_index_next = (char_index < MaxIdx) ? char_index + 16'd1 : char_index;
  end

  // Result formed from the state seen when the terminator arrives.
  always_comb begin
    ok  = (phase == PH_PREFIX) || (phase == PH_DIGITS) || (phase == PH_DONE);
    raw = ovf_flag ? 32'hFFFF_FFFF : accum;
    res = '0;
    if (ok) begin
      if (cfg.signed_mode && raw[31]) begin
        res.value = neg_flag ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        res.value = neg_flag ? (32'd0 - raw) : raw;
      end
      res.end_offset = (phase == PH_DONE) ? stop_index : char_index;
      res.overflowed = ovf_flag;
    end else begin
      res.status = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && is_nul)) begin
      phase         <= PH_WS;
      accum         <= '0;
      ovf_flag      <= 1'b0;
      neg_flag      <= 1'b0;
      eff_base      <= '0;
      progress_seen <= 1'b0;
      char_index    <= '0;
      stop_index    <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      accum         <= accum_next;
      ovf_flag      <= ovf_flag_next;
      neg_flag      <= neg_flag_next;
      eff_base      <= eff_base_next;
      progress_seen <= progress_seen_next;
      char_index    <= char_index_next;
      stop_index    <= stop_index_next;
    end
  end

  `STIP_ASSERT(a_clear_after_nul, clk, rst, res_load |=> (phase == PH_WS && char_index == 16'd0), "string state not cleared after terminator")
  `STIP_ASSERT(a_index_bound, clk, rst, char_index <= MaxIdx, "char index beyond limit")
  `STIP_ASSERT(a_error_zero, clk, rst, (res_load && res.status) |-> (res.value == 32'd0 && res.end_offset == 16'd0 && !res.overflowed), "error result not zeroed")

endmodule

// ----- hdl/stip_out_reg.sv -----
// Result register between the parse step and the result channel.
// Depends on stip_pkg, stip_stream_if and assert_macros.svh.
`include "assert_macros.svh"

module stip_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  stip_pkg::result_t res,
  output logic              can_take,
  stip_stream_if.source     results
);
  import stip_pkg::*;

  logic    full;
  result_t res_q;

  assign can_take      = !full || results.ready;
  assign results.valid = full;
  assign results.data  = res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (results.ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_q <= res;
  end

  `STIP_ASSERT(a_no_overwrite, clk, rst, load |-> (!full || results.ready), "result overwritten before transfer")

endmodule

// ----- hdl/string_to_integer_parser.sv -----
// String-to-integer parser top: config registers, character input register,
// parse step and result register. Depends on stip_pkg, stip_stream_if, stip_step, stip_out_reg.
// Path: a terminator is held in the character input register, and its result then in the
// result register, from which it transfers on the result channel.
// Throughput: one character per cycle, except that a terminator waits while the result
// register is full and unread; the accumulator's multiply-add is combinational.
// Reset: synchronous; radix 0 (auto), signed mode 1, parse state cleared.
module string_to_integer_parser #(
  parameter int MAX_CHARS = 65535
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [stip_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stip_pkg::CFG_DATA_W-1:0] cfg_data,
  stip_stream_if.sink                     chars,
  stip_stream_if.source                   results
);
  import stip_pkg::*;

  cfg_t       cfg;
  logic       ch_valid;
  logic [7:0] ch_q;
  logic       advance, res_load, can_take;
  result_t    res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radix       <= RADIX_AUTO;
      cfg.signed_mode <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RADIX:  cfg.radix       <= cfg_data;
        CFG_SIGNED: cfg.signed_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign chars.ready = !ch_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_valid <= 1'b0;
    end else if (chars.ready) begin
      ch_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) ch_q <= chars.data;
  end

  stip_step #(.MAX_CHARS(MAX_CHARS)) u_step (
    .clk      (clk),
    .rst      (rst),
    .ch_valid (ch_valid),
    .ch       (ch_q),
    .cfg      (cfg),
    .can_take (can_take),
    .advance  (advance),
    .res_load (res_load),
    .res      (res)
  );

  stip_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (res_load),
    .res      (res),
    .can_take (can_take),
    .results  (results)
  );

endmodule
